>>> sv/line_ring_buffer_macros.svh
// Assertion macros shared by the line ring buffer checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LINE_RING_BUFFER_MACROS_SVH
`define LINE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_ring_buffer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_ring_buffer: next-cycle check failed");

`endif

>>> sv/lrb_pkg.sv
// Package for the line ring buffer: field widths, codes, defaults and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lrb_pkg;

    localparam int DEF_SLOTS      = 8;
    localparam int DEF_LINE_BYTES = 32;
    localparam int CHUNK_BYTES    = 4;
    localparam int KW             = $clog2(CHUNK_BYTES);

    localparam int MODE_W  = 2;
    localparam int CHUNK_W = 8 * CHUNK_BYTES;
    localparam int COUNT_W = 3;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int LIMIT_REG_W = 6;
    localparam int DEPTH_REG_W = 4;
    localparam logic [LIMIT_REG_W-1:0] LIMIT_RST = 6'd32;
    localparam logic [DEPTH_REG_W-1:0] DEPTH_RST = 4'd8;

    // Register index, taken from paddr bit 2.
    localparam logic REG_LINE_LIMIT   = 1'b0;
    localparam logic REG_SLOTS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_COMMIT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic    latch;
        logic    clr_fill;
        logic    commit;
        logic    open_line;
        logic    wr_byte;
        logic    add_fill;
        logic    ld_len;
        logic    rd_next;
        logic    emit_reply;
        logic    emit_byte;
        status_t reply_code;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  overflow;
        logic  cnt_zero;
        logic  wr_last;
        logic  len_zero;
        logic  rd_last;
        logic  out_free;
    } dp_stat_t;

endpackage

>>> sv/line_ring_buffer.sv
// Top level of the line ring buffer: APB registers, controller and datapath.
// Uses lrb_pkg, lrb_regs, lrb_ctrl and lrb_dp.
`timescale 1ns / 1ps

// The line ring buffer keeps a queue of text lines in SLOTS fixed slots of
// LINE_BYTES bytes each. An append transfer (mode 0) adds up to four bytes to
// the line being built, a commit (mode 1) closes it, and a read (mode 2)
// streams the oldest line out one byte per result transfer, with last set on
// the final byte. Appends and commits give one result; a full ring, a line
// overflow or an empty ring is reported in status. One item is handled at a
// time: the input takes a new transfer only when the previous item has put
// all its results into the output register. An append stores its bytes one
// per cycle, since the line memory has a single write port; a read streams
// its line through the single read port, which delivers one byte per cycle
// while the output register is free; a read of an empty line fetches its
// stored length before the reply is given. line_limit and slots_in_use must
// be written over APB only while the block is idle; the block itself does
// not enforce this. Values out of range are clamped to 1..LINE_BYTES and
// 2..SLOTS.
module line_ring_buffer #(
    parameter int SLOTS      = lrb_pkg::DEF_SLOTS,
    parameter int LINE_BYTES = lrb_pkg::DEF_LINE_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrb_pkg::ADDR_W-1:0]    paddr,
    input  logic [lrb_pkg::DATA_W-1:0]    pwdata,
    output logic [lrb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lrb_pkg::MODE_W-1:0]    mode,
    input  logic [lrb_pkg::CHUNK_W-1:0]   data_chunk,
    input  logic [lrb_pkg::COUNT_W-1:0]   byte_count,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [lrb_pkg::BYTE_W-1:0]    data_byte,
    output logic                          byte_valid,
    output logic                          last
);

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int DW = $clog2(SLOTS + 1);

    // Clamped register values seen by the datapath.
    logic [LW-1:0]      limit;
    logic [DW-1:0]      depth;

    // Command and status bundles between controller and datapath.
    lrb_pkg::ctrl_cmd_t cmd;
    lrb_pkg::dp_stat_t  stat;

    lrb_regs #(
        .SLOTS      (SLOTS),
        .LINE_BYTES (LINE_BYTES)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit),
        .depth   (depth)
    );

    // The controller sequences each item: decide, store bytes or stream
    // them out, and hand the final result to the output register.
    lrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrb_dp #(
        .SLOTS      (SLOTS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .data_chunk (data_chunk),
        .byte_count (byte_count),
        .limit      (limit),
        .depth      (depth),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last)
    );

endmodule

>>> sv/lrb_regs.sv
// APB register file of the line ring buffer: line_limit and slots_in_use,
// with their saturated working values. Uses lrb_pkg.
`timescale 1ns / 1ps

module lrb_regs #(
    parameter int SLOTS      = lrb_pkg::DEF_SLOTS,
    parameter int LINE_BYTES = lrb_pkg::DEF_LINE_BYTES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrb_pkg::ADDR_W-1:0]   paddr,
    input  logic [lrb_pkg::DATA_W-1:0]   pwdata,
    output logic [lrb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [$clog2(LINE_BYTES+1)-1:0] limit,
    output logic [$clog2(SLOTS+1)-1:0]      depth
);

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int DW = $clog2(SLOTS + 1);

    logic [lrb_pkg::LIMIT_REG_W-1:0] limit_reg;
    logic [lrb_pkg::DEPTH_REG_W-1:0] depth_reg;
    logic                            wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lrb_pkg::LIMIT_RST;
            depth_reg <= lrb_pkg::DEPTH_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                lrb_pkg::REG_LINE_LIMIT:
                begin
                    limit_reg <= pwdata[lrb_pkg::LIMIT_REG_W-1:0];
                end
                lrb_pkg::REG_SLOTS_IN_USE:
                begin
                    depth_reg <= pwdata[lrb_pkg::DEPTH_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lrb_pkg::REG_LINE_LIMIT:   prdata = lrb_pkg::DATA_W'(limit_reg);
            lrb_pkg::REG_SLOTS_IN_USE: prdata = lrb_pkg::DATA_W'(depth_reg);
            default:                   prdata = '0;
        endcase
    end

    // The raw values are kept as written; the logic works on clamped copies.
    always_comb
    begin
        if (limit_reg == '0)
            limit = LW'(1);
        else if (int'(limit_reg) > LINE_BYTES)
            limit = LW'(LINE_BYTES);
        else
            limit = LW'(limit_reg);
    end

    always_comb
    begin
        if (int'(depth_reg) < 2)
            depth = DW'(2);
        else if (int'(depth_reg) > SLOTS)
            depth = DW'(SLOTS);
        else
            depth = DW'(depth_reg);
    end

endmodule

>>> sv/lrb_ctrl.sv
// Controller of the line ring buffer: the sequencing state machine that
// drives the datapath commands. Uses lrb_pkg.
`timescale 1ns / 1ps

module lrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lrb_pkg::dp_stat_t  stat,
    output lrb_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WRITE,
        S_LEN,
        S_RD_DATA,
        S_REPLY
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    lrb_pkg::status_t reply_reg;
    lrb_pkg::status_t reply_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= lrb_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.reply_code = reply_reg;
        state_next     = state_reg;
        reply_next     = reply_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_REPLY;
                reply_next = lrb_pkg::ST_OK;
                case (stat.mode)
                    lrb_pkg::MODE_APPEND:
                    begin
                        if (stat.full)
                            reply_next = lrb_pkg::ST_FULL;
                        else if (stat.overflow)
                        begin
                            cmd.clr_fill = 1'b1;
                            reply_next   = lrb_pkg::ST_OVERFLOW;
                        end
                        else if (!stat.cnt_zero)
                            state_next = S_WRITE;
                    end
                    lrb_pkg::MODE_COMMIT:
                    begin
                        if (stat.full)
                            reply_next = lrb_pkg::ST_FULL;
                        else
                            cmd.commit = 1'b1;
                    end
                    lrb_pkg::MODE_READ:
                    begin
                        if (stat.empty)
                            reply_next = lrb_pkg::ST_EMPTY;
                        else
                        begin
                            cmd.open_line = 1'b1;
                            state_next    = S_LEN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WRITE:
            begin
                cmd.wr_byte = 1'b1;
                if (stat.wr_last)
                begin
                    cmd.add_fill = 1'b1;
                    reply_next   = lrb_pkg::ST_OK;
                    state_next   = S_REPLY;
                end
            end
            S_LEN:
            begin
                if (stat.len_zero)
                begin
                    reply_next = lrb_pkg::ST_OK;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.ld_len = 1'b1;
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (stat.rd_last)
                        state_next = S_IDLE;
                    else
                        cmd.rd_next = 1'b1;
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_reply = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lrb_dp.sv
// Datapath of the line ring buffer: slot pointers, fill counter, line byte
// and length memories, and the output register. Uses lrb_pkg.
`timescale 1ns / 1ps

module lrb_dp #(
    parameter int SLOTS      = lrb_pkg::DEF_SLOTS,
    parameter int LINE_BYTES = lrb_pkg::DEF_LINE_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lrb_pkg::MODE_W-1:0]          mode,
    input  logic [lrb_pkg::CHUNK_W-1:0]         data_chunk,
    input  logic [lrb_pkg::COUNT_W-1:0]         byte_count,
    input  logic [$clog2(LINE_BYTES+1)-1:0]     limit,
    input  logic [$clog2(SLOTS+1)-1:0]          depth,
    input  lrb_pkg::ctrl_cmd_t                  cmd,
    output lrb_pkg::dp_stat_t                   stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [lrb_pkg::BYTE_W-1:0]          data_byte,
    output logic                                byte_valid,
    output logic                                last
);

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int DW = $clog2(SLOTS + 1);
    localparam int PW = $clog2(SLOTS);
    localparam int AW = $clog2(SLOTS * LINE_BYTES);
    localparam int SW = $clog2(LINE_BYTES + lrb_pkg::CHUNK_BYTES + 1);
    localparam int CW = lrb_pkg::COUNT_W;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [DW-1:0] d);
        logic [DW-1:0] n;
        n = DW'(p) + DW'(1);
        return (n >= d) ? '0 : n[PW-1:0];
    endfunction

    lrb_pkg::mode_t                 mode_reg;
    logic [lrb_pkg::CHUNK_W-1:0]    chunk_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_sat;
    logic [lrb_pkg::KW-1:0]         k_reg;
    logic [PW-1:0]                  head_reg;
    logic [PW-1:0]                  tail_reg;
    logic [PW-1:0]                  slot_reg;
    logic [LW-1:0]                  fill_reg;
    logic [LW-1:0]                  len_reg;
    logic [LW-1:0]                  pos_reg;
    logic [LW-1:0]                  len_q;
    logic [lrb_pkg::BYTE_W-1:0]     rdata_reg;
    logic [SW-1:0]                  fill_sum;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  rd_addr;
    logic [LW-1:0]                  rd_pos;
    logic                           out_valid_reg;
    lrb_pkg::status_t               status_reg;
    logic [lrb_pkg::BYTE_W-1:0]     data_byte_reg;
    logic                           byte_valid_reg;
    logic                           last_reg;

    logic [lrb_pkg::BYTE_W-1:0]     line_mem [SLOTS*LINE_BYTES];
    logic [LW-1:0]                  len_mem  [SLOTS];

    assign count_sat = (byte_count > CW'(lrb_pkg::CHUNK_BYTES)) ?
                       CW'(lrb_pkg::CHUNK_BYTES) : byte_count;
    assign fill_sum  = SW'(fill_reg) + SW'(count_reg);

    assign wr_addr = AW'(head_reg) * AW'(LINE_BYTES) + AW'(fill_reg) + AW'(k_reg);
    assign rd_pos  = cmd.ld_len ? '0 : LW'(pos_reg + 1'b1);
    assign rd_addr = AW'(slot_reg) * AW'(LINE_BYTES) + AW'(rd_pos);

    always_comb
    begin
        stat          = '0;
        stat.mode     = mode_reg;
        stat.full     = (advance(head_reg, depth) == tail_reg);
        stat.empty    = (head_reg == tail_reg);
        stat.overflow = (fill_sum > SW'(limit));
        stat.cnt_zero = (count_reg == '0);
        stat.wr_last  = ((CW'(k_reg) + CW'(1)) == count_reg);
        stat.len_zero = (len_q == '0);
        stat.rd_last  = (LW'(pos_reg + 1'b1) == len_reg);
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= lrb_pkg::mode_t'(mode);
            chunk_reg <= data_chunk;
            count_reg <= count_sat;
        end
    end

    // Pointers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
            k_reg    <= '0;
            len_reg  <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            if (cmd.latch)
                k_reg <= '0;
            else if (cmd.wr_byte)
                k_reg <= k_reg + 1'b1;

            if (cmd.clr_fill || cmd.commit)
                fill_reg <= '0;
            else if (cmd.add_fill)
                fill_reg <= LW'(fill_sum);

            if (cmd.commit)
                head_reg <= advance(head_reg, depth);

            if (cmd.open_line)
            begin
                slot_reg <= tail_reg;
                tail_reg <= advance(tail_reg, depth);
            end

            if (cmd.ld_len)
            begin
                len_reg <= len_q;
                pos_reg <= '0;
            end
            else if (cmd.rd_next)
                pos_reg <= LW'(pos_reg + 1'b1);
        end
    end

    // Line byte memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
            line_mem[wr_addr] <= chunk_reg[8*k_reg +: 8];
        if (cmd.ld_len || cmd.rd_next)
            rdata_reg <= line_mem[rd_addr];
    end

    // Line length memory, written on commit and read when a line is opened.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            len_mem[head_reg] <= fill_reg;
        if (cmd.open_line)
            len_q <= len_mem[tail_reg];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_reply || cmd.emit_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_byte)
        begin
            status_reg     <= lrb_pkg::ST_OK;
            data_byte_reg  <= rdata_reg;
            byte_valid_reg <= 1'b1;
            last_reg       <= stat.rd_last;
        end
        else if (cmd.emit_reply)
        begin
            status_reg     <= cmd.reply_code;
            data_byte_reg  <= '0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data_byte  = data_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;

endmodule

>>> sv/lrb_checker.sv
// Port-level checker for the line ring buffer, bound to the top level.
// Uses lrb_pkg and line_ring_buffer_macros.svh.
`timescale 1ns / 1ps
`include "line_ring_buffer_macros.svh"

module lrb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 status,
    input logic [lrb_pkg::BYTE_W-1:0] data_byte,
    input logic                       byte_valid,
    input logic                       last
);

    // A stalled result holds still.
    `LRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(data_byte) && $stable(byte_valid) && $stable(last))
    // Line bytes are only ever sent with an ok status.
    `LRB_ASSERT_IMPL(a_byte_ok, out_valid && byte_valid, status == lrb_pkg::ST_OK)
    // A result without a line byte is the only result of its item.
    `LRB_ASSERT_IMPL(a_single_last, out_valid && !byte_valid, last && (data_byte == '0))
    // Items are handled one at a time, so the input closes after a transfer.
    `LRB_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

bind line_ring_buffer lrb_checker u_lrb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .last       (last)
);
